FILE: rtl/rbsm_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer slot manager package
// Shared types, constants and control structs.
// ----------------------------------------------------------------------------
package rbsm_pkg;

  localparam int unsigned Slots    = 64;
  localparam int unsigned SlotBits = $clog2(Slots);
  localparam int unsigned TagBits  = 16;
  localparam int unsigned NumBits  = 32;

  typedef enum logic [1:0] {
    MODE_ARRIVE  = 2'd0,
    MODE_DELIVER = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FLAG_EMPTY = 2'd0,
    FLAG_FULL  = 2'd1,
    FLAG_TIMED = 2'd2,
    FLAG_RSVD  = 2'd3
  } flag_e;

  typedef enum logic [2:0] {
    V_STORED    = 3'd0,
    V_DUP       = 3'd1,
    V_LATE      = 3'd2,
    V_DELIVERED = 3'd3,
    V_EMPTY     = 3'd4,
    V_TIMEOUT   = 3'd5,
    V_IDLE      = 3'd6,
    V_RSVD      = 3'd7
  } verdict_e;

  typedef enum logic [0:0] {
    REG_START_THRESHOLD = 1'd0,
    REG_TIMEOUT_LIMIT   = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [NumBits-1:0] pkt_num;
    logic [TagBits-1:0] packet_tag;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         verdict;
    logic [5:0]         slot;
    logic [TagBits-1:0] tag_out;
    logic [NumBits-1:0] number_out;
    logic               delivering;
    logic [NumBits-1:0] head_number;
  } out_item_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic exec;
  } ctrl_t;

endpackage

FILE: rtl/reorder_buffer_slot_manager.sv
// ----------------------------------------------------------------------------
// Reorder buffer slot manager
// Slotted receive reorder buffer with delivery start and timeout control.
// ----------------------------------------------------------------------------
// Each transaction goes from acceptance to result in order: capture of the
// item, the registered read of the slot memories, and the decision and
// write-back; a new transaction is accepted in the cycle its predecessor's
// result is taken, so an item is not accepted while the previous one is
// still in flight.
module reorder_buffer_slot_manager (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbsm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rbsm_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import rbsm_pkg::*;

  ctrl_t ctrl;

  rbsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .ctrl_o(ctrl));

  rbsm_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .in_item_i(in_data_i),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .out_item_o(out_data_o));
endmodule

FILE: rtl/rbsm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rbsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: rtl/rbsm_datapath.sv
// ----------------------------------------------------------------------------
// Reorder buffer datapath
// Slot stores, head and newest registers, and the per-item decision logic.
// ----------------------------------------------------------------------------
module rbsm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rbsm_pkg::ctrl_t     ctrl_i,
  input  rbsm_pkg::in_item_t  in_item_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  output rbsm_pkg::out_item_t out_item_o
);
  import rbsm_pkg::*;

  in_item_t           in_q;
  logic [NumBits-1:0] head_q, head_d, newest_q, newest_d;
  logic               start_q, start_d;
  logic [7:0]         run_q, run_d;
  logic [6:0]         thr_q;
  logic [7:0]         lim_q;
  out_item_t          out_q, out_d;

  logic [Slots-1:0]   nx_valid_q;
  logic [SlotBits-1:0] slot_idx;
  logic [NumBits+1:0] slot_raw;
  logic [NumBits-1:0] nx_raw, nx_val, num_raw;
  logic [TagBits-1:0] tag_raw;
  logic               nx_we, st_we;
  logic [NumBits-1:0] nx_wdata;
  flag_e              flag_cur, flag_new;
  logic [NumBits-1:0] span;
  logic [NumBits-1:0] reset_nx;

  always_comb begin
    if (ctrl_i.load_in) begin
      slot_idx = (in_item_i.mode == MODE_ARRIVE) ? in_item_i.pkt_num[SlotBits-1:0]
                                                 : head_q[SlotBits-1:0];
    end else begin
      slot_idx = (in_q.mode == MODE_ARRIVE) ? in_q.pkt_num[SlotBits-1:0]
                                            : head_q[SlotBits-1:0];
    end
  end

  // The slot flag and the next-expected number share one memory word.
  rbsm_ram #(.Width(NumBits+2), .Depth(Slots)) u_nx (
    .clk_i, .we_i(nx_we), .waddr_i(slot_idx), .wdata_i({flag_new, nx_wdata}),
    .re_i(ctrl_i.rd_en), .raddr_i(slot_idx), .rdata_o(slot_raw));
  rbsm_ram #(.Width(TagBits), .Depth(Slots)) u_tag (
    .clk_i, .we_i(st_we), .waddr_i(slot_idx), .wdata_i(in_q.packet_tag),
    .re_i(ctrl_i.rd_en), .raddr_i(slot_idx), .rdata_o(tag_raw));
  rbsm_ram #(.Width(NumBits), .Depth(Slots)) u_num (
    .clk_i, .we_i(st_we), .waddr_i(slot_idx), .wdata_i(in_q.pkt_num),
    .re_i(ctrl_i.rd_en), .raddr_i(slot_idx), .rdata_o(num_raw));

  assign nx_raw   = slot_raw[NumBits-1:0];
  assign reset_nx = NumBits'(slot_idx);
  assign nx_val   = nx_valid_q[slot_idx] ? nx_raw : reset_nx;
  assign flag_cur = nx_valid_q[slot_idx] ? flag_e'(slot_raw[NumBits+1:NumBits])
                                         : FLAG_EMPTY;

  always_comb begin
    head_d   = head_q;
    newest_d = newest_q;
    start_d  = start_q;
    run_d    = run_q;
    nx_we    = 1'b0;
    st_we    = 1'b0;
    nx_wdata = nx_val;
    flag_new = FLAG_EMPTY;
    out_d    = '0;
    out_d.slot = 6'(slot_idx);
    span     = '0;
    if (in_q.mode == MODE_ARRIVE) begin
      out_d.number_out = in_q.pkt_num;
      if (flag_cur != FLAG_FULL && in_q.pkt_num >= nx_val &&
          in_q.pkt_num >= head_q) begin
        if (flag_cur == FLAG_TIMED && in_q.pkt_num == nx_val) begin
          nx_we    = 1'b1;
          nx_wdata = nx_val + NumBits'(Slots);
          out_d.verdict = V_LATE;
        end else begin
          st_we    = 1'b1;
          nx_we    = 1'b1;
          nx_wdata = in_q.pkt_num + NumBits'(Slots);
          flag_new = FLAG_FULL;
          if (newest_q < in_q.pkt_num) begin
            newest_d = in_q.pkt_num;
          end
          out_d.verdict = V_STORED;
        end
      end else begin
        out_d.verdict = V_DUP;
      end
      span = (newest_d >= head_q) ? newest_d - head_q : head_q - newest_d;
      if (span >= NumBits'(thr_q)) begin
        start_d = 1'b1;
      end
    end else if (in_q.mode == MODE_UNUSED || !start_q) begin
      out_d.verdict = V_IDLE;
    end else if (in_q.mode == MODE_DELIVER) begin
      if (flag_cur == FLAG_FULL) begin
        out_d.tag_out    = tag_raw;
        out_d.number_out = num_raw;
        nx_we   = 1'b1;
        head_d  = head_q + 32'd1;
        run_d   = '0;
        out_d.verdict = V_DELIVERED;
      end else begin
        out_d.verdict = V_EMPTY;
      end
    end else begin
      nx_we    = 1'b1;
      flag_new = FLAG_TIMED;
      head_d   = head_q + 32'd1;
      run_d    = run_q + 8'd1;
      if (run_d >= lim_q) begin
        start_d = 1'b0;
        run_d   = '0;
      end
      out_d.verdict = V_TIMEOUT;
    end
    out_d.delivering  = start_d;
    out_d.head_number = head_d;
    if (!ctrl_i.exec) begin
      nx_we   = 1'b0;
      st_we   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      in_q <= in_item_i;
    end
    if (ctrl_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      newest_q   <= '0;
      start_q    <= 1'b0;
      run_q      <= '0;
      thr_q      <= 7'd8;
      lim_q      <= 8'd10;
      nx_valid_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_THRESHOLD: thr_q <= cfg_data_i[6:0];
          REG_TIMEOUT_LIMIT:   lim_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.exec) begin
        head_q   <= head_d;
        newest_q <= newest_d;
        start_q  <= start_d;
        run_q    <= run_d;
        if (nx_we) begin
          nx_valid_q[slot_idx] <= 1'b1;
        end
      end
    end
  end

  assign out_item_o = out_q;
endmodule

FILE: rtl/rbsm_ctrl.sv
// ----------------------------------------------------------------------------
// Reorder buffer controller
// Sequences capture, slot read, execute and result hand-off for each item.
// ----------------------------------------------------------------------------
module rbsm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rbsm_pkg::ctrl_t ctrl_o
);
  import rbsm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ctrl_o.rd_en = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        if (out_ready_i) begin
          if (in_valid_i) begin
            ctrl_o.load_in = 1'b1;
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
